// File: hdl/tsts_pkg.sv
package tsts_pkg;

   localparam int CHAR_W   = 8;
   localparam int VALUE_W  = 40;
   localparam int STATUS_W = 2;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2e;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3a;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_TOO_MANY = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [VALUE_W-1:0] seconds_ms;
      status_type         status;
   } rsp_type;

   function automatic logic [6:0] frac_weight(input logic [1:0] pos);
      logic [6:0] w;
      case (pos)
         2'd0:    w = 7'd100;
         2'd1:    w = 7'd10;
         2'd2:    w = 7'd1;
         default: w = 7'd0;
      endcase
      return w;
   endfunction

endpackage

// File: hdl/tsts_parse.sv
module tsts_parse #(
   parameter int MAX_FIELDS  = 3,
   parameter int FRAC_DIGITS = 3,
   parameter int VAL_W       = 40
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [tsts_pkg::CHAR_W-1:0] char_code,
   output logic                        emit,
   output tsts_pkg::rsp_type           result
);
   import tsts_pkg::*;

   localparam int EW = VAL_W + 7;
   localparam logic [VAL_W-1:0] LIMIT   = '1;
   localparam logic [EW-1:0]    LIMIT_E = EW'(LIMIT);
   localparam logic [1:0]       FC_LAST = 2'(MAX_FIELDS - 1);
   localparam logic [2:0]       FD      = 3'(FRAC_DIGITS);

   logic             in_token_ff, in_token_in;
   logic [VAL_W-1:0] total_ff, total_in;
   logic [VAL_W-1:0] field_ff, field_in;
   logic [1:0]       frac_pos_ff, frac_pos_in;
   logic             point_seen_ff, point_seen_in;
   logic [1:0]       field_count_ff, field_count_in;
   status_type       error_ff, error_in;
   logic             frac_live_ff, frac_live_in;

   logic             ends;
   logic             is_digit;
   logic [3:0]       digit;
   logic [EW-1:0]    total60;
   logic [EW-1:0]    field10;
   logic [EW-1:0]    sum_colon;
   logic [EW-1:0]    sum_int;
   logic [EW-1:0]    sum_frac;
   logic [EW-1:0]    sum_end;

   assign ends = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB) ||
                 (char_code == CHAR_NL) || (char_code == CHAR_NUL);
   assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign digit    = 4'(char_code - CHAR_ZERO);

   assign total60   = (EW'(total_ff) << 6) - (EW'(total_ff) << 2);
   assign field10   = (EW'(field_ff) << 3) + (EW'(field_ff) << 1);
   assign sum_colon = total60 + EW'(field_ff);
   assign sum_end   = sum_colon;
   assign sum_int   = field10 + EW'(14'(digit) * 14'd1000);
   assign sum_frac  = EW'(field_ff) + EW'(10'(digit) * 10'(frac_weight(frac_pos_ff)));

   assign emit = in_token_ff && ends;

   always_comb begin
      result.status     = error_ff;
      result.seconds_ms = '0;
      if (error_ff == STATUS_OK) begin
         if (sum_end > LIMIT_E) begin
            result.status     = STATUS_OVERFLOW;
            result.seconds_ms = VALUE_W'(LIMIT);
         end else begin
            result.seconds_ms = VALUE_W'(sum_end[VAL_W-1:0]);
         end
      end else if (error_ff == STATUS_OVERFLOW) begin
         result.seconds_ms = VALUE_W'(LIMIT);
      end
   end

   always_comb begin
      in_token_in    = in_token_ff;
      total_in       = total_ff;
      field_in       = field_ff;
      frac_pos_in    = frac_pos_ff;
      point_seen_in  = point_seen_ff;
      field_count_in = field_count_ff;
      error_in       = error_ff;
      frac_live_in   = frac_live_ff;
      if (ends) begin
         in_token_in    = 1'b0;
         total_in       = '0;
         field_in       = '0;
         frac_pos_in    = '0;
         point_seen_in  = 1'b0;
         field_count_in = '0;
         error_in       = STATUS_OK;
         frac_live_in   = 1'b0;
      end else begin
         in_token_in = 1'b1;
         if (error_ff == STATUS_OK) begin
            if (char_code == CHAR_COLON) begin
               if (field_count_ff >= FC_LAST) begin
                  error_in = STATUS_TOO_MANY;
               end else if (sum_colon > LIMIT_E) begin
                  error_in = STATUS_OVERFLOW;
                  total_in = LIMIT;
                  field_in = '0;
               end else begin
                  total_in       = sum_colon[VAL_W-1:0];
                  field_in       = '0;
                  frac_live_in   = 1'b0;
                  frac_pos_in    = '0;
                  field_count_in = field_count_ff + 2'd1;
               end
            end else if (char_code == CHAR_POINT && !point_seen_ff) begin
               point_seen_in = 1'b1;
               frac_live_in  = 1'b1;
               frac_pos_in   = '0;
            end else if (is_digit) begin
               if (frac_live_ff) begin
                  if ({1'b0, frac_pos_ff} < FD && sum_frac > LIMIT_E) begin
                     error_in = STATUS_OVERFLOW;
                     total_in = LIMIT;
                     field_in = '0;
                  end else begin
                     if ({1'b0, frac_pos_ff} < FD) begin
                        field_in = sum_frac[VAL_W-1:0];
                     end
                     if (frac_pos_ff != 2'd3) begin
                        frac_pos_in = frac_pos_ff + 2'd1;
                     end
                  end
               end else if (sum_int > LIMIT_E) begin
                  error_in = STATUS_OVERFLOW;
                  total_in = LIMIT;
                  field_in = '0;
               end else begin
                  field_in = sum_int[VAL_W-1:0];
               end
            end else begin
               error_in = STATUS_BAD_CHAR;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff    <= 1'b0;
         total_ff       <= '0;
         field_ff       <= '0;
         frac_pos_ff    <= '0;
         point_seen_ff  <= 1'b0;
         field_count_ff <= '0;
         error_ff       <= STATUS_OK;
         frac_live_ff   <= 1'b0;
      end else if (step) begin
         in_token_ff    <= in_token_in;
         total_ff       <= total_in;
         field_ff       <= field_in;
         frac_pos_ff    <= frac_pos_in;
         point_seen_ff  <= point_seen_in;
         field_count_ff <= field_count_in;
         error_ff       <= error_in;
         frac_live_ff   <= frac_live_in;
      end
   end

endmodule

// File: hdl/tsts_out_reg.sv
module tsts_out_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  tsts_pkg::rsp_type              data,
   output logic                           can_load,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tsts_pkg::VALUE_W-1:0]   rsp_seconds_ms,
   output logic [tsts_pkg::STATUS_W-1:0]  rsp_status
);
   import tsts_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_seconds_ms = data_ff.seconds_ms;
   assign rsp_status     = data_ff.status;

endmodule

// File: hdl/time_string_to_seconds_core.sv
// time string to seconds converter
// req channel: one character byte per transfer on req_char_code. space, tab
// and newline separate tokens; a token holds digits, colons and one point
// (hh:mm:ss.s, mm:ss.s or ss.s). a separator or nul closes the token.
// rsp channel: one transfer per closed token, rsp_seconds_ms in thousandths
// of a second (saturated on overflow) and rsp_status (ok, bad character,
// too many fields, overflow). separators outside a token give no transfer.
// throughput: one character per cycle save while a closing character waits, set
// by the update of the token accumulators between the input register and the
// result register, into which a closing character's result is then loaded.
// reset clears the input register, the token state and the result register.
// while rsp_stall holds a waiting result, characters that close no token keep
// flowing; a closing character waits in the input register and req_stall rises.
module time_string_to_seconds_core #(
   parameter int MAX_FIELDS  = 3,
   parameter int FRAC_DIGITS = 3,
   parameter int ACC_WIDTH   = 40
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tsts_pkg::CHAR_W-1:0]    req_char_code,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tsts_pkg::VALUE_W-1:0]   rsp_seconds_ms,
   output logic [tsts_pkg::STATUS_W-1:0]  rsp_status
);
   import tsts_pkg::*;

   localparam int VAL_W = (ACC_WIDTH < VALUE_W) ? ACC_WIDTH : VALUE_W;
   localparam logic [VALUE_W-1:0] LIMIT = VALUE_W'({VAL_W{1'b1}});

   logic              s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0] s1_char_ff;
   logic              step;
   logic              emit;
   logic              can_load;
   rsp_type           result;

   assign step      = s1_valid_ff && (!emit || can_load);
   assign req_stall = s1_valid_ff && !step;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_char_ff <= req_char_code;
      end
   end

   tsts_parse #(
      .MAX_FIELDS  (MAX_FIELDS),
      .FRAC_DIGITS (FRAC_DIGITS),
      .VAL_W       (VAL_W)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (s1_char_ff),
      .emit      (emit),
      .result    (result)
   );

   tsts_out_reg u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (step && emit),
      .data           (result),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_seconds_ms (rsp_seconds_ms),
      .rsp_status     (rsp_status)
   );

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && emit && rsp_valid && rsp_stall)
      else $error("req_stall without a blocked closing character");

   a_overflow_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OVERFLOW |-> rsp_seconds_ms == LIMIT)
      else $error("overflow result not saturated");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_BAD_CHAR || rsp_status == STATUS_TOO_MANY)
      |-> rsp_seconds_ms == '0)
      else $error("error result carries a value");

   a_blocked_item_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> s1_valid_ff && $stable(s1_char_ff))
      else $error("blocked character lost");

endmodule

// File: dv/tb_time_string_to_seconds_core.sv
`timescale 1ns / 1ps

module tb_time_string_to_seconds_core;
   import tsts_pkg::*;

   localparam int FIELD_MAX    = 3;
   localparam int FRAC_MAX     = 3;
   localparam int RANDOM_CHARS = 900;
   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [VALUE_W-1:0] MS_LIMIT = 40'hff_ffff_ffff;
   localparam logic [63:0] SAT_MS = {24'd0, MS_LIMIT};

   typedef struct packed {
      logic [VALUE_W-1:0] ms;
      status_type         st;
   } token_result_type;

   typedef struct {
      string              body;
      logic [CHAR_W-1:0]  closer;
      bit                 typed;
      logic [VALUE_W-1:0] ms;
      status_type         st;
   } dir_row_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VALUE_W-1:0]  rsp_seconds_ms;
   logic [STATUS_W-1:0] rsp_status;

   // token parser state
   bit                  tok_open = 1'b0;
   logic [63:0]         total_ms = '0;
   logic [63:0]         field_ms = '0;
   logic [1:0]          frac_pos = '0;
   bit                  point_seen = 1'b0;
   bit                  in_frac = 1'b0;
   logic [1:0]          colons = '0;
   status_type          tok_err = STATUS_OK;

   token_result_type    expected_tokens [$];
   logic [CHAR_W-1:0]   token_chars [$];
   int                  chars_sent = 0;
   int                  mismatches = 0;
   int                  quiet_cycles = 0;
   bit                  req_gaps = 1'b1;
   bit                  rsp_gaps = 1'b1;
   bit                  hold_req = 1'b0;
   bit                  hold_done = 1'b0;

   dir_row_type dir_rows [22] = '{
      '{"0",              CHAR_NUL,   1'b1, 40'd0,       STATUS_OK},
      '{"59",             CHAR_TAB,   1'b1, 40'd59000,   STATUS_OK},
      '{"1:00:00",        CHAR_SPACE, 1'b1, 40'd3600000, STATUS_OK},
      '{"12:34.5",        CHAR_NL,    1'b0, 40'd0,       STATUS_OK},
      '{"23:59:59.999",   CHAR_SPACE, 1'b0, 40'd0,       STATUS_OK},
      '{"1.2345",         CHAR_SPACE, 1'b1, 40'd1234,    STATUS_OK},
      '{".5",             CHAR_SPACE, 1'b1, 40'd500,     STATUS_OK},
      '{".",              CHAR_SPACE, 1'b1, 40'd0,       STATUS_OK},
      '{"::",             CHAR_NL,    1'b1, 40'd0,       STATUS_OK},
      '{":5.",            CHAR_SPACE, 1'b0, 40'd0,       STATUS_OK},
      '{"7.0005",         CHAR_TAB,   1'b0, 40'd0,       STATUS_OK},
      '{"1:2:3:4",        CHAR_SPACE, 1'b1, 40'd0,       STATUS_TOO_MANY},
      '{"1:2:3:4.5.x",    CHAR_SPACE, 1'b1, 40'd0,       STATUS_TOO_MANY},
      '{"1.2.3",          CHAR_SPACE, 1'b1, 40'd0,       STATUS_BAD_CHAR},
      '{"1.5:2.5",        CHAR_SPACE, 1'b1, 40'd0,       STATUS_BAD_CHAR},
      '{"12a",            CHAR_SPACE, 1'b1, 40'd0,       STATUS_BAD_CHAR},
      '{"x:::1.2.3",      CHAR_NUL,   1'b1, 40'd0,       STATUS_BAD_CHAR},
      '{"5\377",          CHAR_SPACE, 1'b1, 40'd0,       STATUS_BAD_CHAR},
      '{"1099511627.775", CHAR_SPACE, 1'b1, MS_LIMIT,    STATUS_OK},
      '{"1099511627.776", CHAR_SPACE, 1'b1, MS_LIMIT,    STATUS_OVERFLOW},
      '{"99999999999:1",  CHAR_SPACE, 1'b1, MS_LIMIT,    STATUS_OVERFLOW},
      '{" \t\n",          CHAR_NUL,   1'b0, 40'd0,       STATUS_OK}
   };

   time_string_to_seconds_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_seconds_ms (rsp_seconds_ms),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit is_sep(input logic [CHAR_W-1:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NL || c == CHAR_NUL;
   endfunction

   function automatic void saturate_token();
      tok_err  = STATUS_OVERFLOW;
      total_ms = SAT_MS;
      field_ms = '0;
   endfunction

   function automatic void parse_char(input logic [CHAR_W-1:0] c, output bit done,
                                      output token_result_type res);
      logic [63:0] v;
      logic [63:0] d;
      logic [63:0] w;
      done = 1'b0;
      res  = '0;
      v    = '0;
      if (!tok_open && is_sep(c)) return;
      tok_open = 1'b1;
      if (!is_sep(c)) begin
         if (tok_err != STATUS_OK) return;
         if (c == CHAR_COLON) begin
            if (colons >= FIELD_MAX - 1) begin
               tok_err = STATUS_TOO_MANY;
            end else begin
               v = total_ms * 60 + field_ms;
               if (v > SAT_MS) begin
                  saturate_token();
               end else begin
                  total_ms = v;
                  field_ms = '0;
                  in_frac  = 1'b0;
                  frac_pos = '0;
                  colons   = colons + 2'd1;
               end
            end
         end else if (c == CHAR_POINT && !point_seen) begin
            point_seen = 1'b1;
            in_frac    = 1'b1;
            frac_pos   = '0;
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = 64'(c - CHAR_ZERO);
            if (in_frac) begin
               if (frac_pos < FRAC_MAX) begin
                  case (frac_pos)
                     2'd0:    w = 64'd100;
                     2'd1:    w = 64'd10;
                     default: w = 64'd1;
                  endcase
                  v = field_ms + d * w;
                  if (v > SAT_MS) begin
                     saturate_token();
                     return;
                  end
                  field_ms = v;
               end
               if (frac_pos != 2'd3) frac_pos = frac_pos + 2'd1;
            end else begin
               v = field_ms * 10 + d * 1000;
               if (v > SAT_MS) begin
                  saturate_token();
                  return;
               end
               field_ms = v;
            end
         end else begin
            tok_err = STATUS_BAD_CHAR;
         end
         return;
      end
      if (tok_err == STATUS_OK) begin
         v = total_ms * 60 + field_ms;
         if (v > SAT_MS) tok_err = STATUS_OVERFLOW;
      end
      if (tok_err == STATUS_OVERFLOW) res.ms = MS_LIMIT;
      else if (tok_err == STATUS_OK) res.ms = v[VALUE_W-1:0];
      else res.ms = '0;
      res.st     = tok_err;
      done       = 1'b1;
      tok_open   = 1'b0;
      total_ms   = '0;
      field_ms   = '0;
      frac_pos   = '0;
      point_seen = 1'b0;
      in_frac    = 1'b0;
      colons     = '0;
      tok_err    = STATUS_OK;
   endfunction

   function automatic logic [CHAR_W-1:0] rand_digit();
      return CHAR_ZERO + CHAR_W'($urandom_range(9));
   endfunction

   function automatic void build_token();
      int kind;
      int nf;
      int nd;
      kind = $urandom_range(99);
      if (kind < 70) begin
         nf = $urandom_range(1, 3);
         for (int f = 0; f < nf; f++) begin
            if (f > 0) token_chars.push_back(CHAR_COLON);
            nd = ($urandom_range(19) == 0) ? $urandom_range(8, 13) : $urandom_range(0, 3);
            repeat (nd) token_chars.push_back(rand_digit());
         end
         if ($urandom_range(1) == 1) begin
            token_chars.push_back(CHAR_POINT);
            repeat ($urandom_range(0, 5)) token_chars.push_back(rand_digit());
         end
      end else if (kind < 88) begin
         repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(5))
               0:       token_chars.push_back(CHAR_COLON);
               1:       token_chars.push_back(CHAR_POINT);
               2:       token_chars.push_back(CHAR_W'($urandom_range(8'h21, 8'h7e)));
               default: token_chars.push_back(rand_digit());
            endcase
         end
      end else begin
         repeat ($urandom_range(1, 6)) token_chars.push_back(CHAR_W'($urandom_range(255)));
      end
      repeat ($urandom_range(1, 2)) begin
         case ($urandom_range(3))
            0:       token_chars.push_back(CHAR_SPACE);
            1:       token_chars.push_back(CHAR_TAB);
            2:       token_chars.push_back(CHAR_NL);
            default: token_chars.push_back(CHAR_NUL);
         endcase
      end
   endfunction

   // offer one character and return at the edge of its transfer
   task automatic send_char(input logic [CHAR_W-1:0] c, input bit typed,
                            input token_result_type typed_res);
      bit               done;
      token_result_type res;
      while (req_gaps && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (req_stall);
      if (tok_open || !is_sep(c)) chars_sent++;
      parse_char(c, done, res);
      if (done) expected_tokens.push_back(typed ? typed_res : res);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= rsp_gaps && ($urandom_range(99) < 13);
         end
      end
   end

   always @(posedge clock) begin
      token_result_type exp_tok;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $error("result transfer with nothing expected: seconds_ms %0d status %0d",
                   rsp_seconds_ms, rsp_status);
            mismatches++;
         end else begin
            exp_tok = expected_tokens.pop_front();
            if (rsp_seconds_ms !== exp_tok.ms) begin
               $error("seconds_ms expected %0d actual %0d", exp_tok.ms, rsp_seconds_ms);
               mismatches++;
            end
            if (rsp_status !== exp_tok.st) begin
               $error("status expected %0d actual %0d", exp_tok.st, rsp_status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      token_result_type tr;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         tr.ms = dir_rows[i].ms;
         tr.st = dir_rows[i].st;
         for (int k = 0; k < dir_rows[i].body.len(); k++)
            send_char(dir_rows[i].body[k], 1'b0, tr);
         send_char(dir_rows[i].closer, dir_rows[i].typed, tr);
      end

      // sender pause until every result is back
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_tokens.size() != 0);

      tr         = '0;
      chars_sent = 0;
      while (chars_sent < RANDOM_CHARS) begin
         req_gaps = !(chars_sent >= 300 && chars_sent < 500);
         rsp_gaps = req_gaps;
         if (chars_sent >= 600) hold_req = 1'b1;
         build_token();
         while (token_chars.size() != 0) send_char(token_chars.pop_front(), 1'b0, tr);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_tokens.size() != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_tokens.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
